### src/hsvr_pkg.sv
// Package for the radian-hue HSV to RGB converter.
// Holds field widths, fixed-point constants and the sector code type.
// Depends on nothing; every other file imports it.
package hsvr_pkg;

	localparam int HUE_W = 16;
	localparam int SV_W  = 16;
	localparam int CH_W  = 15;

	localparam logic signed [HUE_W-1:0] HUE_MIN_RAW = -16'sd25735;
	localparam logic signed [HUE_W-1:0] HUE_MAX_RAW = 16'sd25744;
	localparam logic signed [SV_W-1:0]  ONE_Q14     = 16'sd16384;

	localparam logic [28:0] SEXT_K     = 29'd512673957;
	localparam int          SEXT_SHIFT = 26;
	localparam logic [16:0] SEXT_ONE   = 17'd65536;
	localparam logic [18:0] SEXT_FULL  = 19'd393216;

	typedef enum logic [2:0] {
		SEC_000 = 3'd0,
		SEC_060 = 3'd1,
		SEC_120 = 3'd2,
		SEC_180 = 3'd3,
		SEC_240 = 3'd4,
		SEC_300 = 3'd5
	} sector_t;

endpackage

### src/hsvr_if.sv
// Valid/ready channel interfaces for the HSV pixel input and the RGB output.
// Depends on hsvr_pkg for the field widths.
interface hsvr_pix_if import hsvr_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [HUE_W-1:0] hue;
	logic signed [SV_W-1:0]  saturation;
	logic signed [SV_W-1:0]  brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input brightness,
		output ready);
endinterface

interface hsvr_rgb_if import hsvr_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

### src/hsv_to_rgb_radian_hue_top.sv
// HSV to RGB converter with hue in radians, as a four-stage pipeline.
// Depends on hsvr_pkg and the channel interfaces in hsvr_if.sv.
//
// The pixel channel takes hue (signed Q3.13 radians), saturation and
// brightness (signed Q1.14). The color channel returns red, green and blue
// as unsigned Q1.14. A transaction happens when valid and ready are both high.
// Inputs out of range give a black pixel.
// Throughput is one pixel per cycle while the color receiver does not stall;
// the stages are the range check with the hue and chroma multiplies, the
// sector decode, the secondary-term multiply, and the channel routing into
// the output register.
// Each stage has its own valid bit and takes new data whenever it is empty
// or its successor moves, so bubbles close up while the receiver stalls.
// A stalled color transaction holds its data; pixel ready drops only when
// every stage is full.
// Reset clears all valid bits; the pipeline is empty afterwards.
module hsv_to_rgb_radian_hue_top
	import hsvr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	hsvr_pix_if.sink   pixel,
	hsvr_rgb_if.source color
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4 = !valid_s4 || color.ready;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;
	assign pixel.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= pixel.valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	logic        oor_c;
	logic [15:0] neg_hue_c;
	logic [14:0] mag_c;

	always_comb begin
		oor_c = (pixel.hue < HUE_MIN_RAW) || (pixel.hue > HUE_MAX_RAW)
			|| pixel.saturation[SV_W-1] || (pixel.saturation > ONE_Q14)
			|| pixel.brightness[SV_W-1] || (pixel.brightness > ONE_Q14);
		neg_hue_c = 16'(-pixel.hue);
		mag_c = pixel.hue[HUE_W-1] ? neg_hue_c[14:0] : pixel.hue[14:0];
	end

	logic [43:0] prod_h_s1;
	logic [29:0] prod_sv_s1;
	logic        neg_s1, oor_s1;
	logic [14:0] v_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			prod_h_s1  <= 44'(mag_c) * 44'(SEXT_K);
			prod_sv_s1 <= 30'(pixel.saturation[14:0]) * 30'(pixel.brightness[14:0]);
			neg_s1     <= pixel.hue[HUE_W-1];
			oor_s1     <= oor_c;
			v_s1       <= pixel.brightness[14:0];
		end
	end

	logic [17:0] q_c;
	logic [18:0] p_c;
	logic [2:0]  sec_raw_c, sec_c;
	logic [14:0] c_c;
	logic [16:0] f_c, d_c;
	logic [29:0] sv_round_c;

	always_comb begin
		q_c = prod_h_s1[SEXT_SHIFT+17:SEXT_SHIFT];
		p_c = neg_s1 ? (SEXT_FULL - {1'b0, q_c}) : {1'b0, q_c};
		sec_raw_c = p_c[18:16];
		if (!neg_s1) begin
			sec_c = (sec_raw_c > 3'(SEC_120)) ? 3'(SEC_120) : sec_raw_c;
		end else if (sec_raw_c < 3'(SEC_180)) begin
			sec_c = 3'(SEC_180);
		end else if (sec_raw_c > 3'(SEC_300)) begin
			sec_c = 3'(SEC_300);
		end else begin
			sec_c = sec_raw_c;
		end
		sv_round_c = prod_sv_s1 + 30'd8192;
		c_c = sv_round_c[28:14];
		f_c = p_c[16:0];
		d_c = f_c[16] ? {1'b0, f_c[15:0]} : (SEXT_ONE - f_c);
	end

	logic [14:0] c_s2, m_s2;
	logic [16:0] w_s2;
	sector_t     sec_s2;
	logic        oor_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			c_s2   <= c_c;
			m_s2   <= v_s1 - c_c;
			w_s2   <= SEXT_ONE - d_c;
			sec_s2 <= sector_t'(sec_c);
			oor_s2 <= oor_s1;
		end
	end

	logic [31:0] xprod_s3;
	logic [14:0] c_s3, m_s3;
	sector_t     sec_s3;
	logic        oor_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			xprod_s3 <= 32'(c_s2) * 32'(w_s2);
			c_s3     <= c_s2;
			m_s3     <= m_s2;
			sec_s3   <= sec_s2;
			oor_s3   <= oor_s2;
		end
	end

	logic [31:0] x_round_c;
	logic [14:0] x_c, r_c, g_c, b_c;

	always_comb begin
		x_round_c = xprod_s3 + 32'd32768;
		x_c = x_round_c[30:16];
		unique case (sec_s3)
			SEC_000: begin r_c = c_s3; g_c = x_c;  b_c = '0;   end
			SEC_060: begin r_c = x_c;  g_c = c_s3; b_c = '0;   end
			SEC_120: begin r_c = '0;   g_c = c_s3; b_c = x_c;  end
			SEC_180: begin r_c = '0;   g_c = x_c;  b_c = c_s3; end
			SEC_240: begin r_c = x_c;  g_c = '0;   b_c = c_s3; end
			default: begin r_c = c_s3; g_c = '0;   b_c = x_c;  end
		endcase
	end

	logic [CH_W-1:0] red_s4, green_s4, blue_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			red_s4   <= oor_s3 ? '0 : CH_W'(r_c + m_s3);
			green_s4 <= oor_s3 ? '0 : CH_W'(g_c + m_s3);
			blue_s4  <= oor_s3 ? '0 : CH_W'(b_c + m_s3);
		end
	end

	assign color.valid = valid_s4;
	assign color.red   = red_s4;
	assign color.green = green_s4;
	assign color.blue  = blue_s4;

endmodule

### src/hsvr_checker.sv
// Port-level checks for the HSV to RGB converter, bound to its top level.
// Depends on hsvr_pkg and hsv_to_rgb_radian_hue_top.
module hsvr_checker
	import hsvr_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input logic [CH_W-1:0] red,
	input logic [CH_W-1:0] green,
	input logic [CH_W-1:0] blue
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("Color valid is high during reset.");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
			&& $stable(blue))
		else $error("A stalled color transaction changed.");

	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready || !out_valid |-> in_ready)
		else $error("Pixel ready is low although the output can move.");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> red <= CH_W'(16384) && green <= CH_W'(16384)
			&& blue <= CH_W'(16384))
		else $error("A color channel exceeds one.");

endmodule

bind hsv_to_rgb_radian_hue_top hsvr_checker u_hsvr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel.valid),
	.in_ready  (pixel.ready),
	.out_valid (color.valid),
	.out_ready (color.ready),
	.red       (color.red),
	.green     (color.green),
	.blue      (color.blue)
);
